// ----- rtl/rgb_box_downscale_2x2_unit_assert.svh -----
// Assertion macros for the RTL of the downscaler.
`ifndef RGB_BOX_DOWNSCALE_2X2_UNIT_ASSERT_SVH
`define RGB_BOX_DOWNSCALE_2X2_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define RBD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define RBD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/rbd_pkg.sv -----
package rbd_pkg;

   // Channel and register widths.
   localparam int PIX_W   = 8;
   localparam int SUM_W   = PIX_W + 1;
   localparam int TOTAL_W = PIX_W + 2;
   localparam int CSR_W   = 12;
   localparam int ROW_W   = 12;
   localparam int CSR_IDX_W = 1;

   // Frame limits.
   localparam int MAX_WIDTH_DEFAULT = 2048;
   localparam int MIN_DIM           = 2;
   localparam logic [CSR_W-1:0] FRAME_WIDTH_RESET  = 12'd1920;
   localparam logic [CSR_W-1:0] FRAME_HEIGHT_RESET = 12'd1080;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } pixel_type;

   // Horizontal pair sums, one line store entry.
   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } pair_sum_type;

endpackage

// ----- rtl/rbd_req_if.sv -----
interface rbd_req_if import rbd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] in_red;
   logic [PIX_W-1:0] in_green;
   logic [PIX_W-1:0] in_blue;

   modport source (output valid, output in_red, output in_green, output in_blue,
                   input ready);
   modport sink (input valid, input in_red, input in_green, input in_blue,
                 output ready);
endinterface

// ----- rtl/rbd_rsp_if.sv -----
interface rbd_rsp_if import rbd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] out_red;
   logic [PIX_W-1:0] out_green;
   logic [PIX_W-1:0] out_blue;
   logic             row_end;
   logic             frame_end;

   modport source (output valid, output out_red, output out_green, output out_blue,
                   output row_end, output frame_end, input ready);
   modport sink (input valid, input out_red, input out_green, input out_blue,
                 input row_end, input frame_end, output ready);
endinterface

// ----- rtl/rbd_line_store.sv -----
module rbd_line_store import rbd_pkg::*; #(
   parameter int DEPTH = MAX_WIDTH_DEFAULT / 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  pair_sum_type             wr_data,
   output pair_sum_type             rd_data
);

   pair_sum_type line_mem [DEPTH];
   pair_sum_type rd_data_ff;

   // One port: a write or a registered read per cycle; the user must not assert both (not enforced here).
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rgb_box_downscale_2x2_unit.sv -----
// 2x2 box-filter downscaler for RGB video.
// Input pixels arrive on req_port in raster order, one word per handshake.
// Each word on rsp_port is the truncated per-channel average of one 2x2 block,
// with row_end on the last pixel of an output row and frame_end on the last
// pixel of the frame. An odd last column or row is consumed without output.
// frame_width and frame_height are written through the csr_ port; the user
// must do so only while idle, as the block does not enforce it. Throughput is
// one input pixel per clock while rsp_port does not stall. The line store is a
// single-port memory of MAX_WIDTH/2 entries: even rows write one pair sum per
// two pixels, odd rows read it at the same address, so one access per pixel
// suffices. Each result passes the middle stage, then the output register.
// Reset (synchronous, active high) clears the column and row counters and the
// pipeline, and sets 1920 x 1080. The line store needs no clearing pass: every
// odd row reads only entries written by the even row above it.
// When the receiver stalls, the result is held in the output register; one
// more result can wait in the middle stage, after which req_port.ready drops.
`include "rgb_box_downscale_2x2_unit_assert.svh"

module rgb_box_downscale_2x2_unit import rbd_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   rbd_req_if.sink              req_port,
   rbd_rsp_if.source            rsp_port,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int ADDR_W     = $clog2(LINE_DEPTH);
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int DIM_W      = ($clog2(MAX_WIDTH + 1) > CSR_W) ? $clog2(MAX_WIDTH + 1) : CSR_W;

   // Configuration registers.
   logic [CSR_W-1:0] frame_width_ff;
   logic [CSR_W-1:0] frame_height_ff;

   // Frame position and the even-column pixel.
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   pixel_type        held_ff;

   // Middle stage: pair sum waiting for the line store read.
   logic             s1_valid_ff, s1_valid_in;
   pair_sum_type     s1_pair_ff;
   logic             s1_row_end_ff;
   logic             s1_frame_end_ff;

   // Output register.
   logic             out_valid_ff, out_valid_in;
   pixel_type        out_pixel_ff;
   logic             out_row_end_ff;
   logic             out_frame_end_ff;

   logic [DIM_W-1:0] width_ext, width_clamped, col_last, col_used_last, col_ext;
   logic [ROW_W-1:0] height_clamped, row_last, row_used_last;
   logic             in_range, odd_col, odd_row;
   logic             accept, hold_load, line_write, emit;
   logic             row_end, frame_end;
   logic             out_open, s1_move;
   pixel_type        in_pixel;
   pair_sum_type     pair_sum, line_rd_data;

   function automatic logic [PIX_W-1:0] quarter_sum(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
      logic [TOTAL_W-1:0] total;
      total = TOTAL_W'(a) + TOTAL_W'(b);
      return total[TOTAL_W-1:2];
   endfunction

   // Effective frame limits from the registers.
   always_comb begin
      width_ext = DIM_W'(frame_width_ff);
      if (width_ext < DIM_W'(MIN_DIM)) begin
         width_clamped = DIM_W'(MIN_DIM);
      end else if (width_ext > DIM_W'(MAX_WIDTH)) begin
         width_clamped = DIM_W'(MAX_WIDTH);
      end else begin
         width_clamped = width_ext;
      end
      height_clamped = (frame_height_ff < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : frame_height_ff;
      col_last       = width_clamped - 1'b1;
      col_used_last  = {width_clamped[DIM_W-1:1], 1'b0} - 1'b1;
      row_last       = height_clamped - 1'b1;
      row_used_last  = {height_clamped[ROW_W-1:1], 1'b0} - 1'b1;
   end

   // Classify the pixel at the input.
   assign in_pixel   = '{red: req_port.in_red, green: req_port.in_green, blue: req_port.in_blue};
   assign col_ext    = DIM_W'(col_ff);
   assign in_range   = (col_ext <= col_used_last) && (row_ff <= row_used_last);
   assign odd_col    = col_ff[0];
   assign odd_row    = row_ff[0];
   assign accept     = req_port.valid && req_port.ready;
   assign hold_load  = accept && in_range && !odd_col;
   assign line_write = accept && in_range && odd_col && !odd_row;
   assign emit       = accept && in_range && odd_col && odd_row;
   assign row_end    = (col_ext == col_used_last);
   assign frame_end  = row_end && (row_ff == row_used_last);

   // Horizontal pair sum of the held pixel and the current one.
   assign pair_sum.red   = SUM_W'(held_ff.red) + SUM_W'(in_pixel.red);
   assign pair_sum.green = SUM_W'(held_ff.green) + SUM_W'(in_pixel.green);
   assign pair_sum.blue  = SUM_W'(held_ff.blue) + SUM_W'(in_pixel.blue);

   // Pipeline flow control.
   assign out_open       = !out_valid_ff || rsp_port.ready;
   assign s1_move        = s1_valid_ff && out_open;
   assign req_port.ready = !s1_valid_ff || out_open;

   // Next column and row; an out-of-range counter wraps at the next pixel.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_ext >= col_last) begin
            col_in = '0;
            row_in = (row_ff >= row_last) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
            if (row_ff > row_last) begin
               row_in = '0;
            end
         end
      end
   end

   // Valid bits of the two stages.
   always_comb begin
      if (accept) begin
         s1_valid_in = emit;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         held_ff         <= '0;
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_en && (csr_index == CSR_FRAME_WIDTH)) begin
            frame_width_ff <= csr_wdata;
         end
         if (csr_write_en && (csr_index == CSR_FRAME_HEIGHT)) begin
            frame_height_ff <= csr_wdata;
         end
         if (hold_load) begin
            held_ff <= in_pixel;
         end
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers of the two stages.
   always_ff @(posedge clock) begin
      if (emit) begin
         s1_pair_ff      <= pair_sum;
         s1_row_end_ff   <= row_end;
         s1_frame_end_ff <= frame_end;
      end
      if (s1_move) begin
         out_pixel_ff.red   <= quarter_sum(line_rd_data.red, s1_pair_ff.red);
         out_pixel_ff.green <= quarter_sum(line_rd_data.green, s1_pair_ff.green);
         out_pixel_ff.blue  <= quarter_sum(line_rd_data.blue, s1_pair_ff.blue);
         out_row_end_ff     <= s1_row_end_ff;
         out_frame_end_ff   <= s1_frame_end_ff;
      end
   end

   // Line store of even-row pair sums, one entry per column pair.
   rbd_line_store #(
      .DEPTH (LINE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (line_write),
      .rd_en   (emit),
      .addr    (col_ff[ADDR_W:1]),
      .wr_data (pair_sum),
      .rd_data (line_rd_data)
   );

   assign rsp_port.valid     = out_valid_ff;
   assign rsp_port.out_red   = out_pixel_ff.red;
   assign rsp_port.out_green = out_pixel_ff.green;
   assign rsp_port.out_blue  = out_pixel_ff.blue;
   assign rsp_port.row_end   = out_row_end_ff;
   assign rsp_port.frame_end = out_frame_end_ff;

   // Checks on the pipeline and the marks.
   `RBD_ASSERT_IMP(a_frame_end_has_row_end, clock, reset, out_valid_ff && out_frame_end_ff, out_row_end_ff, "frame end without row end")
   `RBD_ASSERT_NXT(a_emit_fills_stage, clock, reset, emit, s1_valid_ff, "completed block lost before the middle stage")
   `RBD_ASSERT_NXT(a_silent_pixel_empties_stage, clock, reset, accept && !emit, !s1_valid_ff, "result invented for a pixel that completes no block")
   `RBD_ASSERT_IMP(a_ready_when_output_free, clock, reset, !out_valid_ff, req_port.ready, "input stalled while the output register is empty")

endmodule
